@@ src/zdle_pkg.sv @@
// ----------------------------------------------------------------------------
// zdle_pkg
// shared types, byte codes and crc helpers for the zdle frame encoder
// ----------------------------------------------------------------------------
`default_nettype none

package zdle_pkg;

    typedef enum logic [1:0] {
        ACT_PAYLOAD = 2'd0,
        ACT_CLOSE   = 2'd1,
        ACT_HEADER  = 2'd2,
        ACT_UNUSED  = 2'd3
    } action_t;

    localparam logic [7:0]  ESC_BYTE   = 8'h18;
    localparam logic [7:0]  PAD_BYTE   = 8'h2A;
    localparam logic [7:0]  BIN32_BYTE = 8'h41;
    localparam logic [7:0]  FLIP_MASK  = 8'h40;
    localparam logic [7:0]  NUL_BYTE   = 8'h00;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

    // position within the byte list of one request
    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] LAST_IDX_PAYLOAD = 4'd0;
    localparam logic [IDX_W-1:0] LAST_IDX_CLOSE   = 4'd5;
    localparam logic [IDX_W-1:0] LAST_IDX_HEADER  = 4'd11;
    localparam logic [IDX_W-1:0] HDR_CRC_IDX      = 4'd8;

    // header body bytes covered by its own crc: type plus four data bytes
    localparam int FOLD_W = 3;
    localparam logic [FOLD_W-1:0] HDR_FOLD_LEN = 3'd5;

    typedef struct packed {
        logic        valid;
        action_t     kind;
        logic [7:0]  value_byte;
        logic [31:0] header_word;
        logic [31:0] crc;        // uncomplemented crc register
        logic        crc_ready;
    } job_t;

    function automatic logic [31:0] crc_fold8(input logic [31:0] crc_in,
                                              input logic [7:0]  data);
        logic [31:0] r;
        r = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (r[0])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    function automatic logic is_special(input logic [7:0] b);
        return (b == 8'h18) || (b == 8'h0D) || (b == 8'h0A) ||
               (b == 8'h11) || (b == 8'h13) || (b == 8'h2A);
    endfunction

endpackage

`default_nettype wire

@@ src/zdle_escaped_crc32_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// zdle_escaped_crc32_frame_encoder
// zmodem binary subpacket and header encoder with zdle escaping and crc-32
// ----------------------------------------------------------------------------
// One output byte leaves per cycle while the receiver is ready. A request
// occupies the encoder until it has produced all its bytes: 1-2 for a
// payload byte, 6-10 for a close, 12-21 for a binary header; an unused
// action code is taken and produces nothing. The next request is taken in
// the cycle the final byte of the current one enters the output register, so
// the output byte stream runs without gaps while both sides keep up. The
// running crc is updated as a payload or close request is taken; a header crc
// is folded one body byte a cycle while its leading bytes go out. The last
// byte of each request is flagged on tlast.
`default_nettype none

module zdle_escaped_crc32_frame_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // value_byte [7:0], header_word [39:8]
    input  wire logic [1:0]  s_axis_tuser,   // action [1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_byte [7:0]
    output logic             m_axis_tlast
);

    zdle_pkg::job_t job;
    logic           job_done;

    zdle_input_stage u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .action      (s_axis_tuser),
        .value_byte  (s_axis_tdata[7:0]),
        .header_word (s_axis_tdata[39:8]),
        .job_done    (job_done),
        .job         (job)
    );

    zdle_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_done  (job_done),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ src/zdle_input_stage.sv @@
// ----------------------------------------------------------------------------
// zdle_input_stage
// takes requests, keeps the running crc and holds the job being sent
// ----------------------------------------------------------------------------
`default_nettype none

module zdle_input_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        action,
    input  wire logic [7:0]        value_byte,
    input  wire logic [31:0]       header_word,
    input  wire logic              job_done,
    output zdle_pkg::job_t         job
);

    logic                           job_valid_reg, job_valid_next;
    zdle_pkg::action_t              kind_reg, kind_next;
    logic [7:0]                     vb_reg, vb_next;
    logic [31:0]                    hw_reg, hw_next;
    logic [31:0]                    job_crc_reg, job_crc_next;
    logic [zdle_pkg::FOLD_W-1:0]    fold_cnt_reg, fold_cnt_next;
    logic [31:0]                    crc_acc_reg, crc_acc_next;
    logic [31:0]                    acc_fold;
    logic [7:0]                     hdr_body;
    logic                           accept;

    assign in_ready = !job_valid_reg || job_done;
    assign accept   = in_valid && in_ready;
    assign acc_fold = zdle_pkg::crc_fold8(crc_acc_reg, value_byte);

    // header crc is folded one body byte a cycle, well before its crc bytes go out
    always_comb
    begin
        case (fold_cnt_reg)
            3'd0:    hdr_body = vb_reg;
            3'd1:    hdr_body = hw_reg[7:0];
            3'd2:    hdr_body = hw_reg[15:8];
            3'd3:    hdr_body = hw_reg[23:16];
            3'd4:    hdr_body = hw_reg[31:24];
            default: hdr_body = zdle_pkg::NUL_BYTE;
        endcase
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        kind_next      = kind_reg;
        vb_next        = vb_reg;
        hw_next        = hw_reg;
        job_crc_next   = job_crc_reg;
        fold_cnt_next  = fold_cnt_reg;
        crc_acc_next   = crc_acc_reg;

        if (job_done)
            job_valid_next = 1'b0;

        if (accept)
        begin
            kind_next = zdle_pkg::action_t'(action);
            vb_next   = value_byte;
            hw_next   = header_word;
            case (zdle_pkg::action_t'(action))
                zdle_pkg::ACT_PAYLOAD:
                begin
                    job_valid_next = 1'b1;
                    crc_acc_next   = acc_fold;
                    job_crc_next   = acc_fold;
                    fold_cnt_next  = zdle_pkg::HDR_FOLD_LEN;
                end
                zdle_pkg::ACT_CLOSE:
                begin
                    job_valid_next = 1'b1;
                    crc_acc_next   = zdle_pkg::CRC_INIT;
                    job_crc_next   = acc_fold;
                    fold_cnt_next  = zdle_pkg::HDR_FOLD_LEN;
                end
                zdle_pkg::ACT_HEADER:
                begin
                    job_valid_next = 1'b1;
                    job_crc_next   = zdle_pkg::CRC_INIT;
                    fold_cnt_next  = '0;
                end
                default:
                begin
                    // unused code: taken and dropped
                end
            endcase
        end
        else if (job_valid_reg && (fold_cnt_reg != zdle_pkg::HDR_FOLD_LEN))
        begin
            job_crc_next  = zdle_pkg::crc_fold8(job_crc_reg, hdr_body);
            fold_cnt_next = fold_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            fold_cnt_reg  <= zdle_pkg::HDR_FOLD_LEN;
            crc_acc_reg   <= zdle_pkg::CRC_INIT;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            fold_cnt_reg  <= fold_cnt_next;
            crc_acc_reg   <= crc_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        vb_reg      <= vb_next;
        hw_reg      <= hw_next;
        job_crc_reg <= job_crc_next;
    end

    always_comb
    begin
        job.valid       = job_valid_reg;
        job.kind        = kind_reg;
        job.value_byte  = vb_reg;
        job.header_word = hw_reg;
        job.crc         = job_crc_reg;
        job.crc_ready   = (fold_cnt_reg == zdle_pkg::HDR_FOLD_LEN);
    end

endmodule

`default_nettype wire

@@ src/zdle_emitter.sv @@
// ----------------------------------------------------------------------------
// zdle_emitter
// walks the byte list of the current job, escapes and registers each byte
// ----------------------------------------------------------------------------
`default_nettype none

module zdle_emitter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire zdle_pkg::job_t    job,
    output logic                   job_done,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_last
);

    logic [zdle_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       half_reg, half_next;
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_byte_reg, out_byte_next;
    logic                       out_last_reg, out_last_next;
    logic [zdle_pkg::IDX_W-1:0] last_idx;
    logic [7:0]                 cur_byte;
    logic [31:0]                crc_c;
    logic                       esc_sp;
    logic                       esc_nul;
    logic                       need_esc;
    logic                       final_byte;
    logic                       step;

    assign crc_c = ~job.crc;
    assign step  = job.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        cur_byte = job.value_byte;
        esc_sp   = 1'b0;
        esc_nul  = 1'b0;
        last_idx = zdle_pkg::LAST_IDX_PAYLOAD;
        case (job.kind)
            zdle_pkg::ACT_PAYLOAD:
            begin
                esc_sp = 1'b1;
            end
            zdle_pkg::ACT_CLOSE:
            begin
                last_idx = zdle_pkg::LAST_IDX_CLOSE;
                esc_sp   = (idx_reg >= 4'd2);
                case (idx_reg)
                    4'd0:    cur_byte = zdle_pkg::ESC_BYTE;
                    4'd1:    cur_byte = job.value_byte;   // end marker goes raw
                    4'd2:    cur_byte = crc_c[31:24];
                    4'd3:    cur_byte = crc_c[23:16];
                    4'd4:    cur_byte = crc_c[15:8];
                    default: cur_byte = crc_c[7:0];
                endcase
            end
            zdle_pkg::ACT_HEADER:
            begin
                last_idx = zdle_pkg::LAST_IDX_HEADER;
                esc_sp   = (idx_reg >= 4'd3);
                // nul escaped in all header body bytes but the final crc byte
                esc_nul  = (idx_reg >= 4'd3) && (idx_reg != zdle_pkg::LAST_IDX_HEADER);
                case (idx_reg)
                    4'd0:    cur_byte = zdle_pkg::PAD_BYTE;
                    4'd1:    cur_byte = zdle_pkg::ESC_BYTE;
                    4'd2:    cur_byte = zdle_pkg::BIN32_BYTE;
                    4'd3:    cur_byte = job.value_byte;
                    4'd4:    cur_byte = job.header_word[7:0];
                    4'd5:    cur_byte = job.header_word[15:8];
                    4'd6:    cur_byte = job.header_word[23:16];
                    4'd7:    cur_byte = job.header_word[31:24];
                    4'd8:    cur_byte = crc_c[31:24];
                    4'd9:    cur_byte = crc_c[23:16];
                    4'd10:   cur_byte = crc_c[15:8];
                    default: cur_byte = crc_c[7:0];
                endcase
            end
            default:
            begin
                cur_byte = job.value_byte;
            end
        endcase
    end

    assign need_esc = (esc_sp && zdle_pkg::is_special(cur_byte)) ||
                      (esc_nul && (cur_byte == zdle_pkg::NUL_BYTE));

    always_comb
    begin
        idx_next       = idx_reg;
        half_next      = half_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        final_byte     = 1'b0;

        if (step)
        begin
            out_valid_next = 1'b1;
            if (need_esc && !half_reg)
            begin
                out_byte_next = zdle_pkg::ESC_BYTE;
                half_next     = 1'b1;
            end
            else
            begin
                out_byte_next = half_reg ? (cur_byte ^ zdle_pkg::FLIP_MASK) : cur_byte;
                half_next     = 1'b0;
                final_byte    = (idx_reg == last_idx);
                idx_next      = final_byte ? '0 : idx_reg + 1'b1;
            end
            out_last_next = final_byte;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign job_done = step && final_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // the flipped half of an escape always belongs to a live job
    a_half_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> job.valid)
        else $error("escape pending without a job");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        job.valid |-> (idx_reg <= last_idx))
        else $error("byte index past end of job");

    a_hdr_crc_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (job.valid && (job.kind == zdle_pkg::ACT_HEADER) &&
         (idx_reg >= zdle_pkg::HDR_CRC_IDX)) |-> job.crc_ready)
        else $error("header crc read before folding finished");

    a_done_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        job_done |=> (out_valid_reg && out_last_reg))
        else $error("job finished without a last byte");

endmodule

`default_nettype wire

@@ tb/sv/tb_zdle_escaped_crc32_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// tb_zdle_escaped_crc32_frame_encoder
// self-checking bench for the zdle escaped crc-32 frame encoder
// ----------------------------------------------------------------------------
// Payload, close, header and unused requests go in on the slave stream. An
// in-bench encoder keeps its own running crc and works out the line bytes
// each accepted request must produce. Every byte taken from the master
// stream is checked against the oldest outstanding one. A short table of
// corner cases runs first, then random subpackets and headers. Both stream
// sides idle at random.
module tb_zdle_escaped_crc32_frame_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PREDICT      = -1;
    localparam int RANDOM_ITEMS = 200;
    localparam int TAIL_CYCLES  = 32;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;    // value_byte [7:0], header_word [39:8]
    logic [1:0]  s_axis_tuser;    // action [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // out_byte [7:0]
    logic        m_axis_tlast;

    typedef struct {
        logic [7:0] out_byte;
        logic       last_of_run;
    } line_byte_t;

    typedef struct packed {
        zdle_pkg::action_t act;
        logic [7:0]        value_byte;
        logic [31:0]       header_word;
        int                n_fixed;
        logic [7:0]        fixed0;
        logic [7:0]        fixed1;
    } directed_row_t;

    localparam int N_DIRECTED = 24;
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{zdle_pkg::ACT_PAYLOAD, 8'h00, 32'h0000_0000, 1, 8'h00, 8'h00},
        '{zdle_pkg::ACT_PAYLOAD, 8'hFF, 32'hFFFF_FFFF, 1, 8'hFF, 8'h00},
        '{zdle_pkg::ACT_PAYLOAD, 8'h18, 32'h0000_0000, 2, 8'h18, 8'h58},
        '{zdle_pkg::ACT_PAYLOAD, 8'h0D, 32'h0000_0000, 2, 8'h18, 8'h4D},
        '{zdle_pkg::ACT_PAYLOAD, 8'h0A, 32'h0000_0000, 2, 8'h18, 8'h4A},
        '{zdle_pkg::ACT_PAYLOAD, 8'h11, 32'h0000_0000, 2, 8'h18, 8'h51},
        '{zdle_pkg::ACT_PAYLOAD, 8'h13, 32'h0000_0000, 2, 8'h18, 8'h53},
        '{zdle_pkg::ACT_PAYLOAD, 8'h2A, 32'h0000_0000, 2, 8'h18, 8'h6A},
        '{zdle_pkg::ACT_CLOSE,   8'h68, 32'h0000_0000, PREDICT, 8'h00, 8'h00},
        '{zdle_pkg::ACT_UNUSED,  8'h00, 32'hFFFF_FFFF, 0, 8'h00, 8'h00},
        // empty subpacket, marker itself a special byte but sent raw
        '{zdle_pkg::ACT_CLOSE,   8'h18, 32'h0000_0000, PREDICT, 8'h00, 8'h00},
        '{zdle_pkg::ACT_HEADER,  8'h00, 32'h0000_0000, PREDICT, 8'h00, 8'h00},
        '{zdle_pkg::ACT_HEADER,  8'hFF, 32'hFFFF_FFFF, PREDICT, 8'h00, 8'h00},
        '{zdle_pkg::ACT_HEADER,  8'h18, 32'h2A13_0A0D, PREDICT, 8'h00, 8'h00},
        '{zdle_pkg::ACT_PAYLOAD, 8'h40, 32'hFFFF_FFFF, 1, 8'h40, 8'h00},
        '{zdle_pkg::ACT_UNUSED,  8'hFF, 32'h0000_0000, 0, 8'h00, 8'h00},
        '{zdle_pkg::ACT_PAYLOAD, 8'h58, 32'h0000_0000, 1, 8'h58, 8'h00},
        '{zdle_pkg::ACT_HEADER,  8'h11, 32'h00FF_0018, PREDICT, 8'h00, 8'h00},
        '{zdle_pkg::ACT_CLOSE,   8'hFF, 32'h0000_0000, PREDICT, 8'h00, 8'h00},
        '{zdle_pkg::ACT_CLOSE,   8'h00, 32'hFFFF_FFFF, PREDICT, 8'h00, 8'h00},
        '{zdle_pkg::ACT_HEADER,  8'h2A, 32'h0000_0000, PREDICT, 8'h00, 8'h00},
        '{zdle_pkg::ACT_UNUSED,  8'h2A, 32'h1234_5678, 0, 8'h00, 8'h00},
        '{zdle_pkg::ACT_PAYLOAD, 8'h2B, 32'h0000_0000, 1, 8'h2B, 8'h00},
        '{zdle_pkg::ACT_CLOSE,   8'h0A, 32'h0000_0000, PREDICT, 8'h00, 8'h00}
    };

    logic [31:0] run_crc;
    logic [7:0]  encoded_q [$];
    line_byte_t  expected_line_q [$];
    int          mismatch_count;

    zdle_escaped_crc32_frame_encoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // bit-serial reflected crc-32, one data bit per step
    function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in;
        for (int k = 0; k < 8; k++)
        begin
            if (c[0] ^ b[k])
                c = {1'b0, c[31:1]} ^ zdle_pkg::CRC_POLY;
            else
                c = {1'b0, c[31:1]};
        end
        return c;
    endfunction

    function automatic void emit_escaped(input logic [7:0] b, input bit nul_too);
        bit hit;
        case (b)
            8'h18, 8'h0D, 8'h0A, 8'h11, 8'h13, 8'h2A: hit = 1'b1;
            default:                                  hit = nul_too && (b == zdle_pkg::NUL_BYTE);
        endcase
        if (hit)
        begin
            encoded_q.push_back(zdle_pkg::ESC_BYTE);
            encoded_q.push_back(b ^ zdle_pkg::FLIP_MASK);
        end
        else
            encoded_q.push_back(b);
    endfunction

    // line bytes of one request, running crc updated as the encoder does
    function automatic void encode_request(input zdle_pkg::action_t act, input logic [7:0] vb,
                                           input logic [31:0] hw);
        logic [7:0]  body [9];
        logic [31:0] hdr_crc;
        logic [31:0] sub_crc;
        encoded_q.delete();
        case (act)
            zdle_pkg::ACT_PAYLOAD:
            begin
                run_crc = crc32_byte(run_crc, vb);
                emit_escaped(vb, 1'b0);
            end
            zdle_pkg::ACT_CLOSE:
            begin
                run_crc = crc32_byte(run_crc, vb);
                sub_crc = ~run_crc;
                encoded_q.push_back(zdle_pkg::ESC_BYTE);
                encoded_q.push_back(vb);
                for (int i = 3; i >= 0; i--)
                    emit_escaped(sub_crc[8*i +: 8], 1'b0);
                run_crc = zdle_pkg::CRC_INIT;
            end
            zdle_pkg::ACT_HEADER:
            begin
                body[0] = vb;
                for (int i = 0; i < 4; i++)
                    body[1+i] = hw[8*i +: 8];
                hdr_crc = zdle_pkg::CRC_INIT;
                for (int i = 0; i < 5; i++)
                    hdr_crc = crc32_byte(hdr_crc, body[i]);
                hdr_crc = ~hdr_crc;
                for (int i = 0; i < 4; i++)
                    body[5+i] = hdr_crc[8*(3-i) +: 8];
                encoded_q.push_back(zdle_pkg::PAD_BYTE);
                encoded_q.push_back(zdle_pkg::ESC_BYTE);
                encoded_q.push_back(zdle_pkg::BIN32_BYTE);
                // nul escaped in all but the final crc byte
                for (int i = 0; i < 9; i++)
                    emit_escaped(body[i], i < 8);
            end
            default: ;
        endcase
    endfunction

    function automatic int idle_length(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // special bytes and extremes turn up far more often than chance
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(99) < 30)
        begin
            case ($urandom_range(7))
                0:       b = 8'h18;
                1:       b = 8'h0D;
                2:       b = 8'h0A;
                3:       b = 8'h11;
                4:       b = 8'h13;
                5:       b = 8'h2A;
                6:       b = 8'h00;
                default: b = 8'hFF;
            endcase
        end
        return b;
    endfunction

    task automatic send_request(input zdle_pkg::action_t act, input logic [7:0] vb,
                                input logic [31:0] hw, input int n_fixed,
                                input logic [7:0] f0, input logic [7:0] f1, input bit calm);
        line_byte_t entry;
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hw, vb};
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        encode_request(act, vb, hw);
        if (n_fixed != PREDICT)
        begin
            encoded_q.delete();
            if (n_fixed > 0)
                encoded_q.push_back(f0);
            if (n_fixed > 1)
                encoded_q.push_back(f1);
        end
        for (int i = 0; i < encoded_q.size(); i++)
        begin
            entry.out_byte    = encoded_q[i];
            entry.last_of_run = (i == encoded_q.size() - 1);
            expected_line_q.push_back(entry);
        end
        gap = idle_length(calm);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom(), 8'($urandom_range(255))};
            s_axis_tuser  <= 2'($urandom_range(3));
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain_line;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_line_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver: stalls of random length, with calm stretches now and then
    initial
    begin
        int hold;
        int cyc;
        m_axis_tready = 1'b0;
        hold = 0;
        cyc  = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold == 0)
                hold = idle_length((cyc / 300) % 3 == 1);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        line_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_line_q.size() == 0)
            begin
                $error("out_byte %02h arrived with nothing outstanding", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_line_q.pop_front();
                if (m_axis_tdata !== want.out_byte)
                begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last_of_run, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int  random_sent;
        int  r;
        int  len;
        bit  calm;
        bit  drained;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = zdle_pkg::ACT_PAYLOAD;
        mismatch_count = 0;
        run_crc        = zdle_pkg::CRC_INIT;
        random_sent    = 0;
        drained        = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].value_byte,
                         DIRECTED_ROWS[i].header_word, DIRECTED_ROWS[i].n_fixed,
                         DIRECTED_ROWS[i].fixed0, DIRECTED_ROWS[i].fixed1, 1'b0);
        drain_line();

        // mostly whole subpackets and headers, a little noise in between
        while (random_sent < RANDOM_ITEMS)
        begin
            calm = ((random_sent / 40) % 4 == 3);
            r = $urandom_range(99);
            if (r < 75)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6);
                repeat (len)
                begin
                    send_request(zdle_pkg::ACT_PAYLOAD, pick_byte(), $urandom(), PREDICT,
                                 8'h00, 8'h00, calm);
                    random_sent++;
                end
                send_request(zdle_pkg::ACT_CLOSE, pick_byte(), $urandom(), PREDICT,
                             8'h00, 8'h00, calm);
                random_sent++;
            end
            else if (r < 93)
            begin
                if ($urandom_range(1))
                    send_request(zdle_pkg::ACT_HEADER, pick_byte(),
                                 {pick_byte(), pick_byte(), pick_byte(), pick_byte()},
                                 PREDICT, 8'h00, 8'h00, calm);
                else
                    send_request(zdle_pkg::ACT_HEADER, pick_byte(), $urandom(), PREDICT,
                                 8'h00, 8'h00, calm);
                random_sent++;
            end
            else
                send_request(zdle_pkg::ACT_UNUSED, pick_byte(), $urandom(), PREDICT,
                             8'h00, 8'h00, calm);

            if (!drained && random_sent >= RANDOM_ITEMS / 2)
            begin
                drain_line();
                drained = 1'b1;
            end
        end
        drain_line();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
src/zdle_pkg.sv
src/zdle_input_stage.sv
src/zdle_emitter.sv
src/zdle_escaped_crc32_frame_encoder.sv
tb/sv/tb_zdle_escaped_crc32_frame_encoder.sv
